FILE: sv/ttes_pkg.sv
package ttes_pkg;

   // field widths of the request and response
   localparam int COORD_W  = 16;
   localparam int TILE_W   = 6;
   localparam int COLOR_W  = 16;
   localparam int STEP_W   = COORD_W + 1;
   localparam int WRAP_W   = 32;
   localparam int SHIFT    = 4;
   localparam int WEIGHT_W = WRAP_W - SHIFT;

   // tile geometry
   localparam int TILE_SIZE      = 32;
   localparam int SUBPIXEL_STEPS = 16;
   localparam int ORIGIN_SCALE   = TILE_SIZE * SUBPIXEL_STEPS;
   localparam int TILE_MAX       = (1 << TILE_W) - 1;
   localparam int ORIGIN_W       = $clog2(TILE_MAX * ORIGIN_SCALE + 1);

   // origin minus vertex, signed, wide enough for either operand
   localparam int PD_W   = ((ORIGIN_W + 1 > COORD_W) ? ORIGIN_W + 1 : COORD_W) + 1;
   // full cross product width, always at least the 32-bit wrap width
   localparam int PROD_W = STEP_W + PD_W;

   // stream packing
   localparam int REQ_FIELDS_W = 6 * COORD_W + 2 * TILE_W + COLOR_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = 6 * STEP_W + 3 * WEIGHT_W + COLOR_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef struct packed {
      logic signed [COORD_W-1:0] vert0_x;
      logic signed [COORD_W-1:0] vert0_y;
      logic signed [COORD_W-1:0] vert1_x;
      logic signed [COORD_W-1:0] vert1_y;
      logic signed [COORD_W-1:0] vert2_x;
      logic signed [COORD_W-1:0] vert2_y;
      logic [TILE_W-1:0]         tile_col;
      logic [TILE_W-1:0]         tile_row;
      logic                      empty_tile;
      logic [COLOR_W-1:0]        tri_color;
   } item_type;

   typedef struct packed {
      logic [STEP_W-1:0]   step_a01;
      logic [STEP_W-1:0]   step_a12;
      logic [STEP_W-1:0]   step_a20;
      logic [STEP_W-1:0]   step_b01;
      logic [STEP_W-1:0]   step_b12;
      logic [STEP_W-1:0]   step_b20;
      logic [WEIGHT_W-1:0] weight0;
      logic [WEIGHT_W-1:0] weight1;
      logic [WEIGHT_W-1:0] weight2;
      logic [COLOR_W-1:0]  color_out;
   } result_type;

endpackage

FILE: sv/ttes_edge.sv
module ttes_edge (
   input  logic signed [ttes_pkg::COORD_W-1:0]  a_x,
   input  logic signed [ttes_pkg::COORD_W-1:0]  a_y,
   input  logic signed [ttes_pkg::COORD_W-1:0]  b_x,
   input  logic signed [ttes_pkg::COORD_W-1:0]  b_y,
   input  logic        [ttes_pkg::ORIGIN_W-1:0] org_x,
   input  logic        [ttes_pkg::ORIGIN_W-1:0] org_y,
   output logic        [ttes_pkg::WEIGHT_W-1:0] weight
);

   logic signed [ttes_pkg::STEP_W-1:0] dx;
   logic signed [ttes_pkg::STEP_W-1:0] dy;
   logic signed [ttes_pkg::PD_W-1:0]   qx;
   logic signed [ttes_pkg::PD_W-1:0]   qy;
   logic signed [ttes_pkg::PROD_W-1:0] p1;
   logic signed [ttes_pkg::PROD_W-1:0] p2;
   logic        [ttes_pkg::WRAP_W-1:0] w;
   logic                               top_left;

   // edge vector
   assign dx = {b_x[ttes_pkg::COORD_W-1], b_x} - {a_x[ttes_pkg::COORD_W-1], a_x};
   assign dy = {b_y[ttes_pkg::COORD_W-1], b_y} - {a_y[ttes_pkg::COORD_W-1], a_y};

   // tile origin relative to the edge start
   assign qx = {{(ttes_pkg::PD_W - ttes_pkg::ORIGIN_W){1'b0}}, org_x}
             - {{(ttes_pkg::PD_W - ttes_pkg::COORD_W){a_x[ttes_pkg::COORD_W-1]}}, a_x};
   assign qy = {{(ttes_pkg::PD_W - ttes_pkg::ORIGIN_W){1'b0}}, org_y}
             - {{(ttes_pkg::PD_W - ttes_pkg::COORD_W){a_y[ttes_pkg::COORD_W-1]}}, a_y};

   // cross product terms, only the low word is kept
   assign p1 = dx * qy;
   assign p2 = dy * qx;

   // top or left edge: horizontal going right, or going down in y
   assign top_left = ((a_y == b_y) && (a_x < b_x)) || (b_y > a_y);

   // bias the non top-left edges and drop the fraction bits
   assign w = p1[ttes_pkg::WRAP_W-1:0] - p2[ttes_pkg::WRAP_W-1:0]
            - {{(ttes_pkg::WRAP_W-1){1'b0}}, ~top_left};
   assign weight = w[ttes_pkg::WRAP_W-1:ttes_pkg::SHIFT];

endmodule

FILE: sv/triangle_tile_edge_setup_top.sv
// path: a request goes through the input register, then the result register, to rsp_tvalid
// throughput: one request per cycle; the only limit is rsp_tready back-pressure
// the request register refills whenever the result register moves on or is empty
// reset: synchronous, active high; clears both valid flags, payload is not reset
module triangle_tile_edge_setup_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y, tile_col, tile_row,
   // tri_color, zero pad
   input  logic [ttes_pkg::REQ_DATA_W-1:0]    req_tdata,
   // empty_tile
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // step_a01, step_a12, step_a20, step_b01, step_b12, step_b20,
   // weight0, weight1, weight2, color_out, zero pad
   output logic [ttes_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   logic                        s1_valid_ff;
   logic                        s1_valid_in;
   ttes_pkg::item_type          s1_item_ff;
   ttes_pkg::item_type          req_item;
   logic                        out_valid_ff;
   logic                        out_valid_in;
   ttes_pkg::result_type        out_ff;
   ttes_pkg::result_type        out_in;
   logic                        s1_load;
   logic                        out_load;
   logic [ttes_pkg::ORIGIN_W-1:0]  org_x;
   logic [ttes_pkg::ORIGIN_W-1:0]  org_y;
   logic [ttes_pkg::WEIGHT_W-1:0]  w0;
   logic [ttes_pkg::WEIGHT_W-1:0]  w1;
   logic [ttes_pkg::WEIGHT_W-1:0]  w2;

   // unpack the request
   assign req_item.vert0_x    = req_tdata[15:0];
   assign req_item.vert0_y    = req_tdata[31:16];
   assign req_item.vert1_x    = req_tdata[47:32];
   assign req_item.vert1_y    = req_tdata[63:48];
   assign req_item.vert2_x    = req_tdata[79:64];
   assign req_item.vert2_y    = req_tdata[95:80];
   assign req_item.tile_col   = req_tdata[101:96];
   assign req_item.tile_row   = req_tdata[107:102];
   assign req_item.tri_color  = req_tdata[123:108];
   assign req_item.empty_tile = req_tuser;

   // pipeline flow control
   assign out_load   = ~out_valid_ff | rsp_tready;
   assign s1_load    = ~s1_valid_ff | out_load;
   assign req_tready = s1_load;

   assign s1_valid_in  = s1_load ? req_tvalid : s1_valid_ff;
   assign out_valid_in = out_load ? s1_valid_ff : out_valid_ff;

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_item_ff <= req_item;
      end
      if (out_load) begin
         out_ff <= out_in;
      end
   end

   // tile origin in subpixel units
   assign org_x = ttes_pkg::ORIGIN_W'(32'(s1_item_ff.tile_col) * ttes_pkg::ORIGIN_SCALE);
   assign org_y = ttes_pkg::ORIGIN_W'(32'(s1_item_ff.tile_row) * ttes_pkg::ORIGIN_SCALE);

   // edge weights: v1->v2, v2->v0, v0->v1
   ttes_edge u_edge0 (
      .a_x    (s1_item_ff.vert1_x),
      .a_y    (s1_item_ff.vert1_y),
      .b_x    (s1_item_ff.vert2_x),
      .b_y    (s1_item_ff.vert2_y),
      .org_x  (org_x),
      .org_y  (org_y),
      .weight (w0)
   );

   ttes_edge u_edge1 (
      .a_x    (s1_item_ff.vert2_x),
      .a_y    (s1_item_ff.vert2_y),
      .b_x    (s1_item_ff.vert0_x),
      .b_y    (s1_item_ff.vert0_y),
      .org_x  (org_x),
      .org_y  (org_y),
      .weight (w1)
   );

   ttes_edge u_edge2 (
      .a_x    (s1_item_ff.vert0_x),
      .a_y    (s1_item_ff.vert0_y),
      .b_x    (s1_item_ff.vert1_x),
      .b_y    (s1_item_ff.vert1_y),
      .org_x  (org_x),
      .org_y  (org_y),
      .weight (w2)
   );

   // steps and weights; for an empty tile the steps are cleared and the weights set to all ones
   always_comb begin
      out_in.color_out = s1_item_ff.tri_color;
      if (s1_item_ff.empty_tile) begin
         out_in.step_a01 = '0;
         out_in.step_a12 = '0;
         out_in.step_a20 = '0;
         out_in.step_b01 = '0;
         out_in.step_b12 = '0;
         out_in.step_b20 = '0;
         out_in.weight0  = '1;
         out_in.weight1  = '1;
         out_in.weight2  = '1;
      end else begin
         out_in.step_a01 = {s1_item_ff.vert0_y[15], s1_item_ff.vert0_y}
                         - {s1_item_ff.vert1_y[15], s1_item_ff.vert1_y};
         out_in.step_a12 = {s1_item_ff.vert1_y[15], s1_item_ff.vert1_y}
                         - {s1_item_ff.vert2_y[15], s1_item_ff.vert2_y};
         out_in.step_a20 = {s1_item_ff.vert2_y[15], s1_item_ff.vert2_y}
                         - {s1_item_ff.vert0_y[15], s1_item_ff.vert0_y};
         out_in.step_b01 = {s1_item_ff.vert1_x[15], s1_item_ff.vert1_x}
                         - {s1_item_ff.vert0_x[15], s1_item_ff.vert0_x};
         out_in.step_b12 = {s1_item_ff.vert2_x[15], s1_item_ff.vert2_x}
                         - {s1_item_ff.vert1_x[15], s1_item_ff.vert1_x};
         out_in.step_b20 = {s1_item_ff.vert0_x[15], s1_item_ff.vert0_x}
                         - {s1_item_ff.vert2_x[15], s1_item_ff.vert2_x};
         out_in.weight0  = w0;
         out_in.weight1  = w1;
         out_in.weight2  = w2;
      end
   end

   // pack the response
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = ttes_pkg::RSP_DATA_W'({out_ff.color_out, out_ff.weight2,
                                              out_ff.weight1, out_ff.weight0,
                                              out_ff.step_b20, out_ff.step_b12,
                                              out_ff.step_b01, out_ff.step_a20,
                                              out_ff.step_a12, out_ff.step_a01});

endmodule

FILE: sv/ttes_check.sv
module ttes_check (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [ttes_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   logic [ttes_pkg::STEP_W-1:0] a_sum;
   logic [ttes_pkg::STEP_W-1:0] b_sum;
   logic                        req_seen;

   // the triangle's edges close, so the a steps and the b steps each sum to zero
   assign a_sum = rsp_tdata[16:0] + rsp_tdata[33:17] + rsp_tdata[50:34];
   assign b_sum = rsp_tdata[67:51] + rsp_tdata[84:68] + rsp_tdata[101:85];
   assign req_seen = req_tvalid & req_tready;

   // a stalled response holds its data
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // nothing comes out right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // y steps close around the triangle
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> a_sum == '0)
      else $error("a steps do not sum to zero");

   // x steps close around the triangle
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> b_sum == '0)
      else $error("b steps do not sum to zero");

   // a request taken into an empty pipe shows up once it has passed the input and result registers
   assert property (@(posedge clock) disable iff (reset)
      req_seen && !rsp_tvalid ##1 !reset |=> rsp_tvalid)
      else $error("response missing two cycles after request");

endmodule

bind triangle_tile_edge_setup_top ttes_check u_check (.*);

FILE: tb/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_COUNT = 900;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int TAIL_CYCLES  = 10;
   localparam int MAX_PRINTS   = 40;

   typedef struct {
      ttes_pkg::item_type shape;
      int unsigned        gap;
   } queued_triangle_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [ttes_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                            req_tuser  = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [ttes_pkg::RSP_DATA_W-1:0] rsp_tdata;

   queued_triangle_type  triangles_to_send[$];
   ttes_pkg::result_type pending_setups[$];
   queued_triangle_type  next_triangle;
   ttes_pkg::item_type   triangle_on_bus;
   int unsigned          idle_count;
   int unsigned          stall_count;
   int unsigned          triangles_sent;
   int unsigned          setups_checked;
   int unsigned          directed_count;
   int unsigned          empty_count;
   int unsigned          error_count;
   int unsigned          cycle_count;

   triangle_tile_edge_setup_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // orient2d of (a,b) against the tile origin, biased by the top-left rule, wrapped at 32 bits
   function automatic logic [ttes_pkg::WEIGHT_W-1:0] edge_weight(int ax, int ay, int bx, int by,
                                                                int px, int py);
      int   w;
      logic top_or_left;
      w = (bx - ax) * (py - ay) - (by - ay) * (px - ax);
      top_or_left = (ay == by && ax < bx) || (by > ay);
      if (!top_or_left) w = w - 1;
      return w[ttes_pkg::WRAP_W-1:ttes_pkg::SHIFT];
   endfunction

   // expected setup for one triangle and tile
   function automatic ttes_pkg::result_type tile_edge_setup(ttes_pkg::item_type t);
      ttes_pkg::result_type r;
      int x0, y0, x1, y1, x2, y2, px, py;
      x0 = $signed(t.vert0_x);
      y0 = $signed(t.vert0_y);
      x1 = $signed(t.vert1_x);
      y1 = $signed(t.vert1_y);
      x2 = $signed(t.vert2_x);
      y2 = $signed(t.vert2_y);
      px = int'(t.tile_col) * ttes_pkg::TILE_SIZE * ttes_pkg::SUBPIXEL_STEPS;
      py = int'(t.tile_row) * ttes_pkg::TILE_SIZE * ttes_pkg::SUBPIXEL_STEPS;
      r.color_out = t.tri_color;
      if (t.empty_tile) begin
         r.step_a01 = '0;
         r.step_a12 = '0;
         r.step_a20 = '0;
         r.step_b01 = '0;
         r.step_b12 = '0;
         r.step_b20 = '0;
         r.weight0  = '1;
         r.weight1  = '1;
         r.weight2  = '1;
      end else begin
         r.step_a01 = ttes_pkg::STEP_W'(y0 - y1);
         r.step_a12 = ttes_pkg::STEP_W'(y1 - y2);
         r.step_a20 = ttes_pkg::STEP_W'(y2 - y0);
         r.step_b01 = ttes_pkg::STEP_W'(x1 - x0);
         r.step_b12 = ttes_pkg::STEP_W'(x2 - x1);
         r.step_b20 = ttes_pkg::STEP_W'(x0 - x2);
         r.weight0  = edge_weight(x1, y1, x2, y2, px, py);
         r.weight1  = edge_weight(x2, y2, x0, y0, px, py);
         r.weight2  = edge_weight(x0, y0, x1, y1, px, py);
      end
      return r;
   endfunction

   // request fields, lowest bits first
   function automatic logic [ttes_pkg::REQ_DATA_W-1:0] pack_triangle(ttes_pkg::item_type t);
      logic [ttes_pkg::REQ_DATA_W-1:0] d;
      d = '0;
      d[0*ttes_pkg::COORD_W +: ttes_pkg::COORD_W] = t.vert0_x;
      d[1*ttes_pkg::COORD_W +: ttes_pkg::COORD_W] = t.vert0_y;
      d[2*ttes_pkg::COORD_W +: ttes_pkg::COORD_W] = t.vert1_x;
      d[3*ttes_pkg::COORD_W +: ttes_pkg::COORD_W] = t.vert1_y;
      d[4*ttes_pkg::COORD_W +: ttes_pkg::COORD_W] = t.vert2_x;
      d[5*ttes_pkg::COORD_W +: ttes_pkg::COORD_W] = t.vert2_y;
      d[6*ttes_pkg::COORD_W +: ttes_pkg::TILE_W]  = t.tile_col;
      d[6*ttes_pkg::COORD_W+ttes_pkg::TILE_W +: ttes_pkg::TILE_W] = t.tile_row;
      d[6*ttes_pkg::COORD_W+2*ttes_pkg::TILE_W +: ttes_pkg::COLOR_W] = t.tri_color;
      return d;
   endfunction

   function automatic ttes_pkg::result_type unpack_setup(logic [ttes_pkg::RSP_DATA_W-1:0] d);
      ttes_pkg::result_type r;
      r.step_a01  = d[0*ttes_pkg::STEP_W +: ttes_pkg::STEP_W];
      r.step_a12  = d[1*ttes_pkg::STEP_W +: ttes_pkg::STEP_W];
      r.step_a20  = d[2*ttes_pkg::STEP_W +: ttes_pkg::STEP_W];
      r.step_b01  = d[3*ttes_pkg::STEP_W +: ttes_pkg::STEP_W];
      r.step_b12  = d[4*ttes_pkg::STEP_W +: ttes_pkg::STEP_W];
      r.step_b20  = d[5*ttes_pkg::STEP_W +: ttes_pkg::STEP_W];
      r.weight0   = d[6*ttes_pkg::STEP_W +: ttes_pkg::WEIGHT_W];
      r.weight1   = d[6*ttes_pkg::STEP_W+ttes_pkg::WEIGHT_W +: ttes_pkg::WEIGHT_W];
      r.weight2   = d[6*ttes_pkg::STEP_W+2*ttes_pkg::WEIGHT_W +: ttes_pkg::WEIGHT_W];
      r.color_out = d[6*ttes_pkg::STEP_W+3*ttes_pkg::WEIGHT_W +: ttes_pkg::COLOR_W];
      return r;
   endfunction

   task automatic report_error(string msg);
      if (error_count < MAX_PRINTS) $display("tb_top: ERROR %s", msg);
      error_count++;
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         report_error($sformatf("setup %0d: %s got %h expected %h",
                                setups_checked, name, got, want));
   endtask

   // clamp a coordinate to the signed 16-bit range
   function automatic logic [ttes_pkg::COORD_W-1:0] clamp_coord(int v);
      if (v > 32767) return ttes_pkg::COORD_W'(32767);
      if (v < -32768) return ttes_pkg::COORD_W'(-32768);
      return ttes_pkg::COORD_W'(v);
   endfunction

   task automatic add_triangle(int x0, int y0, int x1, int y1, int x2, int y2,
                               int col, int row, bit empty, int color);
      queued_triangle_type q;
      q.shape.vert0_x    = ttes_pkg::COORD_W'(x0);
      q.shape.vert0_y    = ttes_pkg::COORD_W'(y0);
      q.shape.vert1_x    = ttes_pkg::COORD_W'(x1);
      q.shape.vert1_y    = ttes_pkg::COORD_W'(y1);
      q.shape.vert2_x    = ttes_pkg::COORD_W'(x2);
      q.shape.vert2_y    = ttes_pkg::COORD_W'(y2);
      q.shape.tile_col   = ttes_pkg::TILE_W'(col);
      q.shape.tile_row   = ttes_pkg::TILE_W'(row);
      q.shape.empty_tile = empty;
      q.shape.tri_color  = ttes_pkg::COLOR_W'(color);
      q.gap              = $urandom_range(0, 15);
      triangles_to_send.push_back(q);
      directed_count++;
   endtask

   // random triangle: full range, near the tile origin, shared y on an edge, or tiny
   function automatic ttes_pkg::item_type random_triangle();
      ttes_pkg::item_type t;
      int                 px, py, pick;
      t.tile_col   = ttes_pkg::TILE_W'($urandom_range(0, ttes_pkg::TILE_MAX));
      t.tile_row   = ttes_pkg::TILE_W'($urandom_range(0, ttes_pkg::TILE_MAX));
      t.empty_tile = ($urandom_range(0, 7) == 0);
      t.tri_color  = ttes_pkg::COLOR_W'($urandom);
      px = int'(t.tile_col) * ttes_pkg::ORIGIN_SCALE;
      py = int'(t.tile_row) * ttes_pkg::ORIGIN_SCALE;
      t.vert0_x = ttes_pkg::COORD_W'($urandom);
      t.vert0_y = ttes_pkg::COORD_W'($urandom);
      t.vert1_x = ttes_pkg::COORD_W'($urandom);
      t.vert1_y = ttes_pkg::COORD_W'($urandom);
      t.vert2_x = ttes_pkg::COORD_W'($urandom);
      t.vert2_y = ttes_pkg::COORD_W'($urandom);
      case ($urandom_range(0, 3))
         1: begin
            t.vert0_x = clamp_coord(px + $urandom_range(0, 2047) - 1024);
            t.vert0_y = clamp_coord(py + $urandom_range(0, 2047) - 1024);
            t.vert1_x = clamp_coord(px + $urandom_range(0, 2047) - 1024);
            t.vert1_y = clamp_coord(py + $urandom_range(0, 2047) - 1024);
            t.vert2_x = clamp_coord(px + $urandom_range(0, 2047) - 1024);
            t.vert2_y = clamp_coord(py + $urandom_range(0, 2047) - 1024);
         end
         2: begin
            // one horizontal edge, sometimes a collapsed edge
            pick = $urandom_range(0, 2);
            if (pick == 0) t.vert2_y = t.vert1_y;
            else if (pick == 1) t.vert0_y = t.vert2_y;
            else t.vert1_y = t.vert0_y;
            if ($urandom_range(0, 3) == 0) t.vert1_x = t.vert0_x;
         end
         3: begin
            t.vert0_x = clamp_coord($urandom_range(0, 63) - 32);
            t.vert0_y = clamp_coord($urandom_range(0, 63) - 32);
            t.vert1_x = clamp_coord($urandom_range(0, 63) - 32);
            t.vert1_y = clamp_coord($urandom_range(0, 63) - 32);
            t.vert2_x = clamp_coord($urandom_range(0, 63) - 32);
            t.vert2_y = clamp_coord($urandom_range(0, 63) - 32);
         end
         default: ;
      endcase
      return t;
   endfunction

   // request driver: wait out each triangle's gap, then hold it until accepted
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         idle_count = 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            pending_setups.push_back(tile_edge_setup(triangle_on_bus));
            triangles_sent++;
            if (triangle_on_bus.empty_tile) empty_count++;
         end
         if (triangles_to_send.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (idle_count < triangles_to_send[0].gap) begin
            req_tvalid <= 1'b0;
            idle_count++;
         end else begin
            next_triangle   = triangles_to_send.pop_front();
            triangle_on_bus = next_triangle.shape;
            req_tdata  <= pack_triangle(triangle_on_bus);
            req_tuser  <= triangle_on_bus.empty_tile;
            req_tvalid <= 1'b1;
            idle_count = 0;
         end
      end
   end

   // response monitor with random back-pressure, calm stretches every few hundred setups
   always @(posedge clock) begin
      ttes_pkg::result_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = unpack_setup(rsp_tdata);
            if (pending_setups.size() == 0) begin
               report_error($sformatf("setup %0d arrived with nothing outstanding",
                                      setups_checked));
            end else begin
               want = pending_setups.pop_front();
               check_field("step_a01", got.step_a01, want.step_a01);
               check_field("step_a12", got.step_a12, want.step_a12);
               check_field("step_a20", got.step_a20, want.step_a20);
               check_field("step_b01", got.step_b01, want.step_b01);
               check_field("step_b12", got.step_b12, want.step_b12);
               check_field("step_b20", got.step_b20, want.step_b20);
               check_field("weight0", got.weight0, want.weight0);
               check_field("weight1", got.weight1, want.weight1);
               check_field("weight2", got.weight2, want.weight2);
               check_field("color_out", got.color_out, want.color_out);
            end
            setups_checked++;
            stall_count = ((setups_checked / 100) % 4 >= 2) ? 0 : $urandom_range(0, 15);
         end
         if (stall_count > 0) begin
            rsp_tready <= 1'b0;
            stall_count--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top: timeout after %0d cycles", cycle_count);
         $display("tb_top: done, errors");
         $finish;
      end
   end

   initial begin
      queued_triangle_type q;

      // directed: range extremes
      add_triangle(0, 0, 0, 0, 0, 0, 0, 0, 0, 16'h0000);
      add_triangle(32767, 32767, 32767, 32767, 32767, 32767, 63, 63, 0, 16'hFFFF);
      add_triangle(-32768, -32768, -32768, -32768, -32768, -32768, 63, 0, 0, 16'h8001);
      add_triangle(-32768, -32768, 32767, 32767, 32767, -32768, 63, 63, 0, 16'h1234);
      add_triangle(32767, 32767, -32768, -32768, -32768, 32767, 0, 63, 0, 16'hFEDC);
      // top edge with increasing x, then the same edge reversed
      add_triangle(500, 900, 100, 200, 900, 200, 1, 1, 0, 16'h0F0F);
      add_triangle(500, 900, 900, 200, 100, 200, 1, 1, 0, 16'hF0F0);
      // left edge, y increasing along it
      add_triangle(600, 400, 100, 100, 50, 800, 0, 1, 0, 16'h3333);
      // collapsed edge and a single point
      add_triangle(300, 300, 700, 700, 700, 700, 2, 2, 0, 16'h4444);
      add_triangle(-5, -5, -5, -5, -5, -5, 5, 7, 0, 16'h5555);
      // vertex sitting on the tile origin
      add_triangle(1024, 1536, 2048, 1536, 1024, 3000, 2, 3, 0, 16'h6666);
      // products that wrap past 32 bits
      add_triangle(0, 32767, -32768, -32768, 32767, -32768, 63, 63, 0, 16'h7777);
      add_triangle(32767, -32768, -32768, 32767, 32767, 32767, 63, 63, 0, 16'h8888);
      // empty tiles
      add_triangle(123, -456, 789, -1011, 1213, -1415, 9, 17, 1, 16'hA5A5);
      add_triangle(0, 0, 0, 0, 0, 0, 0, 0, 1, 16'h0000);
      add_triangle(32767, 32767, -32768, -32768, 32767, -32768, 63, 63, 1, 16'hFFFF);
      // collinear and tiny triangles, and a large one far from its tile
      add_triangle(0, 0, 100, 100, 200, 200, 0, 0, 0, 16'h9999);
      add_triangle(-1, -1, 1, -1, 0, 1, 0, 0, 0, 16'hAAAA);
      add_triangle(-20000, -30000, -10000, -25000, -15000, -100, 63, 0, 0, 16'hBBBB);
      // alternating bit patterns
      add_triangle(16'h5555, 16'h5555, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA,
                   21, 42, 0, 16'h5A5A);
      add_triangle(16'hAAAA, 16'hAAAA, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555,
                   42, 21, 0, 16'hA5A5);

      // random part, with stretches of back-to-back requests
      for (int i = 0; i < RANDOM_COUNT; i++) begin
         q.shape = random_triangle();
         q.gap   = ((i / 100) % 4 == 1 || (i / 100) % 4 == 2) ? 0 : $urandom_range(0, 15);
         triangles_to_send.push_back(q);
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // drain everything, then give the pipeline time to show any stray setup
      while (triangles_to_send.size() != 0 || req_tvalid || pending_setups.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_setups.size() != 0)
         report_error($sformatf("%0d setups never arrived", pending_setups.size()));

      $display("tb_top: %0d triangle requests (%0d directed, %0d empty tiles), %0d checked",
               triangles_sent, directed_count, empty_count, setups_checked);
      $display("tb_top: random stalls on both sides with back-to-back stretches, %0d mismatches",
               error_count);
      if (error_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
